### src/pcm_mixdown_delta_sigma_dac_unit_defines.svh
// ----------------------------------------------------------------------------
// PCM mixdown delta-sigma DAC assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PCM_MIXDOWN_DELTA_SIGMA_DAC_UNIT_DEFINES_SVH
`define PCM_MIXDOWN_DELTA_SIGMA_DAC_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PMDSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmdsd assertion failed");

// next-cycle implication, disabled during reset
`define PMDSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmdsd assertion failed");

// next-cycle implication, active through reset
`define PMDSD_ASSERT_NXT_NR(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pmdsd assertion failed");

`endif

### src/pmdsd_pkg.sv
// ----------------------------------------------------------------------------
// PCM mixdown delta-sigma DAC package
// Shared constants, codes and types.
// ----------------------------------------------------------------------------
package pmdsd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int ACCUM_WIDTH_DEF  = 24;

    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNEL_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SAMPLE_FORMAT = 4'd1;

    localparam logic [1:0] FMT_U8    = 2'd0;
    localparam logic [1:0] FMT_S16LE = 2'd1;

    localparam logic [3:0] CHANNEL_COUNT_RST = 4'd1;
    localparam logic [1:0] SAMPLE_FORMAT_RST = FMT_U8;

    localparam logic [LEVEL_W-1:0] LEVEL_MID  = 8'd128;
    localparam logic [LEVEL_W-1:0] SIGN_FLIP  = 8'h80;
    localparam logic [LEVEL_W:0]   MID_OFFSET = 9'd128;
    localparam logic [LEVEL_W:0]   FULL_STEP  = 9'd255;

    typedef struct packed {
        logic [3:0] channel_count;
        logic [1:0] sample_format;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_ACC
    } back_state_t;

endpackage

### src/pmdsd_front.sv
// ----------------------------------------------------------------------------
// PCM mixdown front end
// Assembles bytes into channel levels and frames, pushes completed frames.
// ----------------------------------------------------------------------------
module pmdsd_front import pmdsd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int CNT_W        = $clog2(MAX_CHANNELS + 1),
    parameter int SUM_W        = $clog2(MAX_CHANNELS * 255 + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [LEVEL_W-1:0]       data_byte,
    input  logic                     stream_start,
    output logic                     push_valid,
    output logic [SUM_W+CNT_W:0]     push_data,
    input  logic                     push_ready
);

    localparam logic [4:0] MAX_C = 5'(MAX_CHANNELS);

    logic [CNT_W-1:0]   pos_reg, pos_next, pos_base, pos_new, chan_n;
    logic [SUM_W-1:0]   sum_reg, sum_next, sum_base, sum_new;
    logic               phase_reg, phase_next, phase_base;
    logic               pend_reg, pend_next, clear_base;
    logic [4:0]         cnt_ext, n_ext;
    logic [LEVEL_W-1:0] level;
    logic               is16, take_chan, frame_done, accept;

    always_comb begin
        cnt_ext = {1'b0, cfg.channel_count};
        if (cnt_ext == 5'd0) begin
            n_ext = 5'd1;
        end else if (cnt_ext > MAX_C) begin
            n_ext = MAX_C;
        end else begin
            n_ext = cnt_ext;
        end
        chan_n = CNT_W'(n_ext);
    end

    always_comb begin
        pos_base   = stream_start ? '0 : pos_reg;
        sum_base   = stream_start ? '0 : sum_reg;
        phase_base = stream_start ? 1'b0 : phase_reg;
        clear_base = stream_start | pend_reg;
        is16       = (cfg.sample_format == FMT_S16LE);
        take_chan  = !is16 || phase_base;
        if (is16) begin
            level = data_byte ^ SIGN_FLIP;
        end else if (cfg.sample_format == FMT_U8) begin
            level = data_byte;
        end else begin
            level = LEVEL_MID;
        end
        sum_new    = sum_base + SUM_W'(level);
        pos_new    = pos_base + CNT_W'(1);
        frame_done = take_chan && (pos_new >= chan_n);
        in_ready   = push_ready;
        accept     = in_valid && in_ready;
        push_valid = accept && frame_done;
        push_data  = {clear_base, chan_n, sum_new};

        pos_next   = pos_reg;
        sum_next   = sum_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        if (accept) begin
            phase_next = is16 && !phase_base;
            if (!take_chan) begin
                pos_next  = pos_base;
                sum_next  = sum_base;
                pend_next = clear_base;
            end else if (frame_done) begin
                pos_next  = '0;
                sum_next  = '0;
                pend_next = 1'b0;
            end else begin
                pos_next  = pos_new;
                sum_next  = sum_new;
                pend_next = clear_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            phase_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

### src/pmdsd_fifo.sv
// ----------------------------------------------------------------------------
// PCM mixdown frame queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pmdsd_fifo import pmdsd_pkg::*; #(
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_wr, do_rd;

    always_comb begin
        wr_ready    = (count_reg != 2'd2);
        rd_valid    = (count_reg != 2'd0);
        rd_data     = entry_reg[rd_ptr_reg];
        do_wr       = wr_valid && wr_ready;
        do_rd       = rd_valid && rd_ready;
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/pmdsd_back.sv
// ----------------------------------------------------------------------------
// PCM mixdown back end
// Serial divide of the frame sum, then first-order delta-sigma update.
// ----------------------------------------------------------------------------
module pmdsd_back import pmdsd_pkg::*; #(
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF,
    parameter int CNT_W       = 4,
    parameter int SUM_W       = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [SUM_W+CNT_W:0] pop_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 speaker_bit,
    output logic [LEVEL_W-1:0]   mixed_level
);

    localparam int ITER_W = $clog2(SUM_W);
    localparam int W      = ACCUM_WIDTH;

    back_state_t        state_reg, state_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   rem_reg, rem_next, div_n_reg, div_n_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [W-1:0]       acc_reg, acc_next, acc_sat;
    logic               valid_reg, valid_next, bit_reg, bit_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [CNT_W:0]     trial, trial_sub;
    logic               ge;
    logic [LEVEL_W:0]   delta;
    logic [W:0]         acc_ext;
    logic               acc_pos, out_free;

    always_comb begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        trial_sub = trial - {1'b0, div_n_reg};
        ge        = (trial >= {1'b0, div_n_reg});
        delta     = {1'b0, quo_reg[LEVEL_W-1:0]} - MID_OFFSET;
        acc_ext   = {acc_reg[W-1], acc_reg} + {{(W-LEVEL_W){delta[LEVEL_W]}}, delta};
        if (acc_ext[W] != acc_ext[W-1]) begin
            acc_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            acc_sat = acc_ext[W-1:0];
        end
        acc_pos  = !acc_sat[W-1] && (|acc_sat);
        out_free = !valid_reg || out_ready;

        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_n_next = div_n_reg;
        iter_next  = iter_reg;
        acc_next   = acc_reg;
        valid_next = valid_reg && !out_ready;
        bit_next   = bit_reg;
        level_next = level_reg;
        pop_ready  = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    quo_next   = pop_data[SUM_W-1:0];
                    div_n_next = pop_data[SUM_W+CNT_W-1:SUM_W];
                    rem_next   = '0;
                    iter_next  = ITER_W'(SUM_W - 1);
                    if (pop_data[SUM_W+CNT_W]) begin
                        acc_next = '0;
                    end
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                rem_next = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], ge};
                if (iter_reg == '0) begin
                    state_next = BK_ACC;
                end else begin
                    iter_next = iter_reg - ITER_W'(1);
                end
            end
            BK_ACC: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    bit_next   = acc_pos;
                    level_next = quo_reg[LEVEL_W-1:0];
                    acc_next   = acc_pos ? (acc_sat - W'(FULL_STEP)) : acc_sat;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        div_n_reg <= div_n_next;
        iter_reg  <= iter_next;
        bit_reg   <= bit_next;
        level_reg <= level_next;
    end

    assign out_valid   = valid_reg;
    assign speaker_bit = bit_reg;
    assign mixed_level = level_reg;

endmodule

### src/pcm_mixdown_delta_sigma_dac_unit.sv
// A frame-completing byte enters the frame queue, then passes through the back-end steps
// (load, one quotient bit per cycle in the serial divider, accumulator update).
// Throughput: one byte per cycle while the two-entry frame queue has room; the
// back end takes no new frame until the last one has finished its accumulator update.
// Reset: synchronous, active low; clears frame position, accumulator, queue and
// output valid, and loads channel_count = 1, sample_format = 8-bit unsigned.
// ----------------------------------------------------------------------------
// PCM mixdown delta-sigma DAC unit
// Mixes interleaved PCM channels per frame and emits one delta-sigma bit.
// ----------------------------------------------------------------------------
module pcm_mixdown_delta_sigma_dac_unit import pmdsd_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int ACCUM_WIDTH  = ACCUM_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte, [8] stream_start, rest zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [0] speaker_bit, [8:1] mixed_level, rest zero
);

    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W  = $clog2(MAX_CHANNELS * 255 + 1);
    localparam int ITEM_W = SUM_W + CNT_W + 1;

    cfg_t               cfg_reg, cfg_next;
    logic               push_valid, push_ready, pop_valid, pop_ready;
    logic [ITEM_W-1:0]  push_data, pop_data;
    logic               speaker_bit;
    logic [LEVEL_W-1:0] mixed_level;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_CHANNEL_COUNT: cfg_next.channel_count = cfg_data;
                CFG_IDX_SAMPLE_FORMAT: cfg_next.sample_format = cfg_data[1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count <= CHANNEL_COUNT_RST;
            cfg_reg.sample_format <= SAMPLE_FORMAT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pmdsd_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .data_byte    (s_tdata[LEVEL_W-1:0]),
        .stream_start (s_tdata[LEVEL_W]),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .push_ready   (push_ready)
    );

    pmdsd_fifo #(
        .DATA_W   (ITEM_W)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    pmdsd_back #(
        .ACCUM_WIDTH (ACCUM_WIDTH),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .speaker_bit (speaker_bit),
        .mixed_level (mixed_level)
    );

    assign m_tdata = {{(M_TDATA_W-LEVEL_W-1){1'b0}}, mixed_level, speaker_bit};

endmodule

### src/pmdsd_checker.sv
// ----------------------------------------------------------------------------
// PCM mixdown delta-sigma DAC checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "pcm_mixdown_delta_sigma_dac_unit_defines.svh"

module pmdsd_checker import pmdsd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `PMDSD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `PMDSD_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `PMDSD_ASSERT_NXT_NR(a_reset_idle, aclk, !aresetn, !m_tvalid)
    `PMDSD_ASSERT_IMP(a_bit_above_mid, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[8:1] > LEVEL_MID)

endmodule

bind pcm_mixdown_delta_sigma_dac_unit pmdsd_checker u_pmdsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
